>>> rtl/core/u2c_pkg.sv
`timescale 1ns / 1ps

package u2c_pkg;

   localparam int U2C_QUEUE_DEPTH = 2;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int PEND_W = 2;

   // one queued operation for the back end
   typedef struct packed {
      logic            lookup;
      logic [CP_W-1:0] value;
   } u2c_item_type;

   // code points of the upper half of code page 437, index 0 is byte 0x80
   localparam logic [15:0] CP437_HIGH [128] = '{
      16'd199, 16'd252, 16'd233, 16'd226, 16'd228, 16'd224, 16'd229, 16'd231,
      16'd234, 16'd235, 16'd232, 16'd239, 16'd238, 16'd236, 16'd196, 16'd197,
      16'd201, 16'd230, 16'd198, 16'd244, 16'd246, 16'd242, 16'd251, 16'd249,
      16'd255, 16'd214, 16'd220, 16'd162, 16'd163, 16'd165, 16'd8359, 16'd402,
      16'd225, 16'd237, 16'd243, 16'd250, 16'd241, 16'd209, 16'd170, 16'd186,
      16'd191, 16'd8976, 16'd172, 16'd189, 16'd188, 16'd161, 16'd171, 16'd187,
      16'd9617, 16'd9618, 16'd9619, 16'd9474, 16'd9508, 16'd9569, 16'd9570, 16'd9558,
      16'd9557, 16'd9571, 16'd9553, 16'd9559, 16'd9565, 16'd9564, 16'd9563, 16'd9488,
      16'd9492, 16'd9524, 16'd9516, 16'd9500, 16'd9472, 16'd9532, 16'd9566, 16'd9567,
      16'd9562, 16'd9556, 16'd9577, 16'd9574, 16'd9568, 16'd9552, 16'd9580, 16'd9575,
      16'd9576, 16'd9572, 16'd9573, 16'd9561, 16'd9560, 16'd9554, 16'd9555, 16'd9579,
      16'd9578, 16'd9496, 16'd9484, 16'd9608, 16'd9604, 16'd9612, 16'd9616, 16'd9600,
      16'd945, 16'd223, 16'd915, 16'd960, 16'd931, 16'd963, 16'd181, 16'd964,
      16'd934, 16'd920, 16'd937, 16'd948, 16'd8734, 16'd966, 16'd949, 16'd8745,
      16'd8801, 16'd177, 16'd8805, 16'd8804, 16'd8992, 16'd8993, 16'd247, 16'd8776,
      16'd176, 16'd8729, 16'd183, 16'd8730, 16'd8319, 16'd178, 16'd9632, 16'd160
   };

   // table entries are distinct, so or-ing the matching indexes gives the match
   function automatic logic [BYTE_W-1:0] cp437_index(input logic [CP_W-1:0] cp);
      logic [BYTE_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < 128; i++) begin
         if (cp == {5'b0, CP437_HIGH[i]}) begin
            idx = idx | {1'b1, 7'(i)};
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/core/u2c_stream_ifs.sv
`timescale 1ns / 1ps

interface u2c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface u2c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;

   modport source (output valid, output char_out, input ready);
   modport sink (input valid, input char_out, output ready);
endinterface

>>> rtl/core/utf8_to_cp437_byte_mapper_core.sv
`timescale 1ns / 1ps

// UTF-8 to code page 437 mapper. Takes one byte per transaction on req_if and
// gives at most one display byte per transaction on rsp_if: plain bytes pass
// through, a completed multi-byte sequence gives its code page 437 index plus
// 128 (or 0 if the character has no code page 437 form), and lead bytes and
// continuation bytes inside a sequence give nothing. A byte can be taken every
// cycle while the queue is not full; a result passes through the classify stage,
// the small queue between the stages and the output register that holds the
// table lookup result. The front end keeps taking bytes while a result waits,
// until the queue of QueueDepth entries is full.
module utf8_to_cp437_byte_mapper_core #(
   parameter int QueueDepth = u2c_pkg::U2C_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   u2c_req_if.sink       req_if,
   u2c_rsp_if.source     rsp_if
);
   import u2c_pkg::*;

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_not_empty;
   u2c_item_type q_push_item;
   u2c_item_type q_pop_item;

   u2c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_byte   (req_if.byte_in),
      .q_full    (q_full),
      .push      (q_push),
      .push_item (q_push_item)
   );

   u2c_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_pop_item)
   );

   u2c_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (q_pop_item),
      .pop         (q_pop),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_char    (rsp_if.char_out)
   );

endmodule

>>> rtl/core/u2c_front.sv
`timescale 1ns / 1ps

module u2c_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 q_full,
   output logic                 push,
   output u2c_pkg::u2c_item_type push_item
);
   import u2c_pkg::*;

   logic [PEND_W-1:0] pending_ff, pending_in;
   logic [CP_W-1:0]   acc_ff, acc_in;
   logic              accept;
   logic [CP_W-1:0]   acc_shift;

   assign in_ready  = !q_full;
   assign accept    = in_valid && !q_full;
   assign acc_shift = {acc_ff[CP_W-7:0], in_byte[5:0]};

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      push       = 1'b0;
      push_item  = '{lookup: 1'b0, value: {{(CP_W-BYTE_W){1'b0}}, in_byte}};
      if (accept) begin
         if (pending_ff != '0) begin
            // any byte continues a pending sequence, lead bytes too
            pending_in = pending_ff - 1'b1;
            acc_in     = acc_shift;
            if (pending_ff == PEND_W'(1)) begin
               push      = 1'b1;
               push_item = '{lookup: 1'b1, value: acc_shift};
               acc_in    = '0;
            end
         end else if (in_byte[7:3] == 5'b11110) begin
            pending_in = PEND_W'(3);
            acc_in     = {{(CP_W-3){1'b0}}, in_byte[2:0]};
         end else if (in_byte[7:4] == 4'b1110) begin
            pending_in = PEND_W'(2);
            acc_in     = {{(CP_W-4){1'b0}}, in_byte[3:0]};
         end else if (in_byte[7:5] == 3'b110) begin
            pending_in = PEND_W'(1);
            acc_in     = {{(CP_W-5){1'b0}}, in_byte[4:0]};
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         acc_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

>>> rtl/core/u2c_queue.sv
`timescale 1ns / 1ps

module u2c_queue #(
   parameter int Depth = u2c_pkg::U2C_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u2c_pkg::u2c_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output u2c_pkg::u2c_item_type pop_item
);
   import u2c_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   u2c_item_type         slot_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/u2c_back.sv
`timescale 1ns / 1ps

module u2c_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  u2c_pkg::u2c_item_type q_item,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_char
);
   import u2c_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] char_ff, char_in;

   assign pop       = q_not_empty && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_char  = char_ff;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (pop) begin
         valid_in = 1'b1;
         char_in  = q_item.lookup ? cp437_index(q_item.value) : q_item.value[BYTE_W-1:0];
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

endmodule

>>> rtl/core/u2c_checker.sv
`timescale 1ns / 1ps

module u2c_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char
);

   // nothing left over from before reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char))
      else $error("stalled response changed");

   // a fresh result comes from an earlier accepted transaction, by way of the queue and the output register
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // a full queue never stalls an idle output side
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled while output is empty");

endmodule

bind utf8_to_cp437_byte_mapper_core u2c_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_char  (rsp_if.char_out)
);
